/* sv/mbet_pkg.sv */
// Shared types and constants for the escape-time evaluator.
// Holds the register map, the register file layout and the iteration state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbet_pkg;

  // Fixed widths of the register file and result fields.
  localparam int MAX_ITER_W  = 16;
  localparam int START_W     = 32;
  localparam int STEP_W      = 31;
  localparam int SIZE_W      = 13;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int ITER_W      = 16;
  localparam int GLYPH_W     = 2;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_ITER     = 3'd0,
    CFG_START_X      = 3'd1,
    CFG_START_Y      = 3'd2,
    CFG_STEP_X       = 3'd3,
    CFG_STEP_Y       = 3'd4,
    CFG_IMAGE_WIDTH  = 3'd5,
    CFG_IMAGE_HEIGHT = 3'd6
  } cfg_idx_t;

  // Register file contents.
  typedef struct packed {
    logic        [MAX_ITER_W-1:0] max_iter;
    logic signed [START_W-1:0]    start_x;
    logic signed [START_W-1:0]    start_y;
    logic        [STEP_W-1:0]     step_x;
    logic        [STEP_W-1:0]     step_y;
    logic        [SIZE_W-1:0]     image_width;
    logic        [SIZE_W-1:0]     image_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_iter:     16'd200,
    start_x:      32'shE000_0000,
    start_y:      32'sh0800_0000,
    step_x:       31'd1342177,
    step_y:       31'd2684354,
    image_width:  13'd200,
    image_height: 13'd100
  };

  // Glyph code for a point that stays bounded.
  localparam logic [GLYPH_W-1:0] GLYPH_INSIDE = 2'd0;

  // Iteration engine states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

/* sv/mbet_pixel_if.sv */
// Pixel request channel: valid/ready handshake with a column and row index.
// Depends on nothing but its INDEX_BITS parameter.
`timescale 1ns / 1ps
`default_nettype none

interface mbet_pixel_if #(
  parameter int INDEX_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] pixel_col;
  logic [INDEX_BITS-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

`default_nettype wire

/* sv/mbet_result_if.sv */
// Result channel: valid/ready handshake with escape count, flags and glyph class.
// Depends on mbet_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mbet_result_if;
  import mbet_pkg::*;

  logic               valid;
  logic               ready;
  logic [ITER_W-1:0]  iterations;
  logic               inside_res;
  logic [GLYPH_W-1:0] glyph;
  logic               out_of_range;

  modport source (output valid, output iterations, output inside_res, output glyph,
                  output out_of_range, input ready);
  modport sink   (input valid, input iterations, input inside_res, input glyph,
                  input out_of_range, output ready);
endinterface

`default_nettype wire

/* sv/mbet_cfg_if.sv */
// Register write channel: valid/ready handshake with register index and data.
// Depends on mbet_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mbet_cfg_if;
  import mbet_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/mandelbrot_escape_time.sv */
// Escape-time evaluator for one pixel at a time.
// Pixel beats arrive on the pixel channel (column, row); each yields exactly one
// beat on the result channel: escape count, inside flag, glyph class and an
// out-of-range flag. Registers are written on the cfg channel, which is always
// ready; write them only while no pixel is in flight.
// A pixel stops on the step limit or the component bound in the multiply state,
// or on the magnitude test in the update state; an out-of-range pixel skips the
// engine's loop and goes straight to the output. The engine takes a new pixel
// only once its last result is in the output register, and each step of its single
// multiply and update loop runs through B_MUL (squares and cross product), then
// B_ADD (the escape test and new z).
// The front end maps the pixel to c and feeds a two-entry queue, so up to three
// further pixels are taken while the engine works or the output stalls.
// When the receiver stalls, the output register holds its beat, the engine waits
// with its next result, and the pixel channel drops ready once the queue and the front stage are full.
// Reset (rst, synchronous) empties the queue and pipeline and loads the default
// registers: 200 steps, a 200 by 100 image of the standard view.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 28,
  parameter int INDEX_BITS = 12
) (
  input  logic          clk,
  input  logic          rst,
  mbet_pixel_if.sink    pixel,
  mbet_result_if.source result,
  mbet_cfg_if.sink      cfg
);
  import mbet_pkg::*;

  localparam int QW = 1 + 2 * COORD_BITS;

  cfg_t regs;

  logic                         push_valid;
  logic                         push_ready;
  logic                         push_oor;
  logic signed [COORD_BITS-1:0] push_cx;
  logic signed [COORD_BITS-1:0] push_cy;
  logic                         pop_valid;
  logic                         pop_ready;
  logic [QW-1:0]                pop_data;

  // Register file.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_idx_t'(cfg.index))
        CFG_MAX_ITER:     regs.max_iter     <= cfg.data[MAX_ITER_W-1:0];
        CFG_START_X:      regs.start_x      <= signed'(cfg.data[START_W-1:0]);
        CFG_START_Y:      regs.start_y      <= signed'(cfg.data[START_W-1:0]);
        CFG_STEP_X:       regs.step_x       <= cfg.data[STEP_W-1:0];
        CFG_STEP_Y:       regs.step_y       <= cfg.data[STEP_W-1:0];
        CFG_IMAGE_WIDTH:  regs.image_width  <= cfg.data[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: regs.image_height <= cfg.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  mbet_front #(
    .COORD_BITS (COORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .pixel      (pixel),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_oor   (push_oor),
    .push_cx    (push_cx),
    .push_cy    (push_cy)
  );

  mbet_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   ({push_oor, push_cx, push_cy}),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  mbet_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_oor   (pop_data[QW-1]),
    .pop_cx    (signed'(pop_data[2*COORD_BITS-1:COORD_BITS])),
    .pop_cy    (signed'(pop_data[COORD_BITS-1:0])),
    .result    (result)
  );

endmodule

`default_nettype wire

/* sv/mbet_front.sv */
// Front end: takes pixel beats, flags out-of-range pixels and maps the pixel to c.
// Depends on mbet_pkg and mbet_pixel_if.
`timescale 1ns / 1ps
`default_nettype none

module mbet_front #(
  parameter int COORD_BITS = 32,
  parameter int INDEX_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mbet_pkg::cfg_t               regs,
  mbet_pixel_if.sink                   pixel,
  output logic                         push_valid,
  input  logic                         push_ready,
  output logic                         push_oor,
  output logic signed [COORD_BITS-1:0] push_cx,
  output logic signed [COORD_BITS-1:0] push_cy
);
  import mbet_pkg::*;

  localparam int PW   = INDEX_BITS + STEP_W;
  localparam int SUMW = (PW + 2 > COORD_BITS + 1) ? PW + 2 : COORD_BITS + 1;
  localparam int CW   = (INDEX_BITS > SIZE_W) ? INDEX_BITS : SIZE_W;

  logic          s1_valid;
  logic          s1_oor;
  logic [PW-1:0] prod_x;
  logic [PW-1:0] prod_y;

  logic                   load;
  logic                   col_oor;
  logic                   row_oor;
  logic signed [SUMW-1:0] sum_x;
  logic signed [SUMW-1:0] sum_y;

  // Clamp a wide signed value to the coordinate range.
  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SUMW-1:0] v);
    logic [SUMW-COORD_BITS:0] top;
    top = v[SUMW-1:COORD_BITS-1];
    if (top == '0 || top == '1) begin
      return v[COORD_BITS-1:0];
    end else if (v[SUMW-1]) begin
      return {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

  // One stage: the stage frees up whenever its content moves into the queue.
  assign pixel.ready = !s1_valid || push_ready;
  assign load        = pixel.valid && pixel.ready;

  // Range check against the configured image size.
  assign col_oor = CW'(pixel.pixel_col) >= CW'(regs.image_width);
  assign row_oor = CW'(pixel.pixel_row) >= CW'(regs.image_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
  end

  // Index times step, registered before the add.
  always_ff @(posedge clk) begin
    if (load) begin
      s1_oor <= col_oor || row_oor;
      prod_x <= PW'(pixel.pixel_col) * PW'(regs.step_x);
      prod_y <= PW'(pixel.pixel_row) * PW'(regs.step_y);
    end
  end

  // Corner plus or minus the offset, then clamp.
  always_comb begin
    sum_x = {{(SUMW-START_W){regs.start_x[START_W-1]}}, regs.start_x}
          + {{(SUMW-PW){1'b0}}, prod_x};
    sum_y = {{(SUMW-START_W){regs.start_y[START_W-1]}}, regs.start_y}
          - {{(SUMW-PW){1'b0}}, prod_y};
  end

  assign push_valid = s1_valid;
  assign push_oor   = s1_oor;
  assign push_cx    = sat(sum_x);
  assign push_cy    = sat(sum_y);

endmodule

`default_nettype wire

/* sv/mbet_queue.sv */
// Small register queue that decouples the front end from the iteration engine.
// Depends on mbet_pkg only through the depth the top level passes in.
`timescale 1ns / 1ps
`default_nettype none

module mbet_queue #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  fill;

  logic push;
  logic pop;

  assign in_ready  = fill != CNTW'(DEPTH);
  assign out_valid = fill != '0;
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

/* sv/mbet_back.sv */
// Iteration engine: runs z <- z^2 + c for one point at a time and drives results.
// Depends on mbet_pkg and mbet_result_if.
`timescale 1ns / 1ps
`default_nettype none

module mbet_back #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mbet_pkg::cfg_t               regs,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  logic                         pop_oor,
  input  logic signed [COORD_BITS-1:0] pop_cx,
  input  logic signed [COORD_BITS-1:0] pop_cy,
  mbet_result_if.source                result
);
  import mbet_pkg::*;

  localparam int AW   = (COORD_BITS > FRAC_BITS + 2) ? COORD_BITS : FRAC_BITS + 2;
  localparam int OPW  = FRAC_BITS + 2;
  localparam int PRW  = 2 * OPW;
  localparam int XXW  = FRAC_BITS + 3;
  localparam int XYW  = FRAC_BITS + 4;
  localparam int SW   = ((COORD_BITS > FRAC_BITS + 5) ? COORD_BITS : FRAC_BITS + 5) + 1;
  localparam logic [AW-1:0]  TWO  = AW'(1) << (FRAC_BITS + 1);
  localparam logic [XXW:0]   FOUR = (XXW + 1)'(1) << (FRAC_BITS + 2);

  back_state_t state;
  back_state_t state_next;

  logic                         oor;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] x;
  logic signed [COORD_BITS-1:0] y;
  logic [ITER_W-1:0]            count;
  logic [1:0]                   mod3;
  logic [XXW-1:0]               xx;
  logic [XXW-1:0]               yy;
  logic [XYW-1:0]               xy;
  logic                         xy_neg;

  logic               out_valid;
  logic [ITER_W-1:0]  out_iterations;
  logic               out_inside;
  logic [GLYPH_W-1:0] out_glyph;
  logic               out_oor;

  logic                  pop;
  logic                  mul_go;
  logic                  step;
  logic                  load_out;
  logic [COORD_BITS-1:0] ax_c;
  logic [COORD_BITS-1:0] ay_c;
  logic [AW-1:0]         ax;
  logic [AW-1:0]         ay;
  logic                  big;
  logic                  at_limit;
  logic [PRW-1:0]        prod_xx;
  logic [PRW-1:0]        prod_yy;
  logic [PRW-1:0]        prod_xy;
  logic [XXW:0]          mag2;
  logic                  escape;
  logic signed [SW-1:0]  new_x;
  logic signed [SW-1:0]  new_y;
  logic signed [SW-1:0]  xy_s;
  logic                  in_set;

  // Clamp a wide signed value to the coordinate range.
  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SW-1:0] v);
    logic [SW-COORD_BITS:0] top;
    top = v[SW-1:COORD_BITS-1];
    if (top == '0 || top == '1) begin
      return v[COORD_BITS-1:0];
    end else if (v[SW-1]) begin
      return {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

  // Magnitudes and the early bound check on each component.
  always_comb begin
    ax_c     = x[COORD_BITS-1] ? COORD_BITS'(~x + 1'b1) : COORD_BITS'(x);
    ay_c     = y[COORD_BITS-1] ? COORD_BITS'(~y + 1'b1) : COORD_BITS'(y);
    ax       = AW'(ax_c);
    ay       = AW'(ay_c);
    big      = (ax > TWO) || (ay > TWO);
    at_limit = count == regs.max_iter;
    prod_xx  = PRW'(ax[OPW-1:0]) * PRW'(ax[OPW-1:0]);
    prod_yy  = PRW'(ay[OPW-1:0]) * PRW'(ay[OPW-1:0]);
    prod_xy  = PRW'(ax[OPW-1:0]) * PRW'(ay[OPW-1:0]);
  end

  // Escape test on the registered squares and the next z.
  always_comb begin
    mag2   = {1'b0, xx} + {1'b0, yy};
    escape = mag2 > FOUR;
    xy_s   = xy_neg ? -SW'(xy) : SW'(xy);
    new_x  = SW'(xx) - SW'(yy) + SW'(cx);
    new_y  = xy_s + SW'(cy);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (pop_valid) begin
          state_next = pop_oor ? B_EMIT : B_MUL;
        end
      end
      B_MUL: begin
        state_next = (at_limit || big) ? B_EMIT : B_ADD;
      end
      B_ADD: begin
        state_next = escape ? B_EMIT : B_MUL;
      end
      B_EMIT: begin
        if (!out_valid || result.ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop_ready = 1'b0;
    mul_go    = 1'b0;
    step      = 1'b0;
    load_out  = 1'b0;
    case (state)
      B_IDLE: pop_ready = 1'b1;
      B_MUL:  mul_go    = !(at_limit || big);
      B_ADD:  step      = !escape;
      B_EMIT: load_out  = !out_valid || result.ready;
      default: ;
    endcase
  end

  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers of the iteration.
  always_ff @(posedge clk) begin
    if (pop) begin
      oor   <= pop_oor;
      cx    <= pop_cx;
      cy    <= pop_cy;
      x     <= pop_cx;
      y     <= pop_cy;
      count <= '0;
      mod3  <= 2'd0;
    end else if (step) begin
      x     <= sat(new_x);
      y     <= sat(new_y);
      count <= count + 1'b1;
      mod3  <= (mod3 == 2'd2) ? 2'd0 : mod3 + 2'd1;
    end
    if (mul_go) begin
      xx     <= prod_xx[FRAC_BITS +: XXW];
      yy     <= prod_yy[FRAC_BITS +: XXW];
      xy     <= prod_xy[FRAC_BITS-1 +: XYW];
      xy_neg <= x[COORD_BITS-1] ^ y[COORD_BITS-1];
    end
  end

  // Output register: holds a beat until the receiver takes it.
  assign in_set = !oor && at_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_iterations <= count;
      out_inside     <= in_set;
      out_glyph      <= (oor || in_set) ? GLYPH_INSIDE : {1'b0, mod3[1] & ~mod3[0]} + mod3 + 2'd1
                                                         - {1'b0, mod3[1] & ~mod3[0]};
      out_oor        <= oor;
    end
  end

  assign result.valid        = out_valid;
  assign result.iterations   = out_iterations;
  assign result.inside_res   = out_inside;
  assign result.glyph        = out_glyph;
  assign result.out_of_range = out_oor;

endmodule

`default_nettype wire

/* sim/mandelbrot_escape_time_test.sv */
// Self-checking bench for the escape-time evaluator: a directed table, then random phases.
// Every pixel beat is predicted in the bench and compared field by field at the result channel.
// Depends on mbet_pkg, the three channel interfaces and mandelbrot_escape_time.
`timescale 1ns / 1ps

module mandelbrot_escape_time_test;
  import mbet_pkg::*;

  localparam int COORD_BITS      = 32;
  localparam int FRAC_BITS       = 28;
  localparam int INDEX_BITS      = 12;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 20;
  localparam int RUN_LIMIT_NS    = 6_000_000;

  localparam longint COORD_HI = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam longint ESC_TWO  = longint'(2) << FRAC_BITS;
  localparam longint ESC_FOUR = longint'(4) << FRAC_BITS;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

  // A few Q4.28 values used by the directed table.
  localparam logic [CFG_DATA_W-1:0] Q_MINUS_TWO = 32'hE000_0000;
  localparam logic [CFG_DATA_W-1:0] Q_FOUR      = 32'h4000_0000;
  localparam logic [CFG_DATA_W-1:0] Q_MOST_POS  = 32'h7FFF_FFFF;
  localparam logic [CFG_DATA_W-1:0] Q_MOST_NEG  = 32'h8000_0000;

  typedef struct packed {
    logic [ITER_W-1:0]  iterations;
    logic               inside_res;
    logic [GLYPH_W-1:0] glyph;
    logic               out_of_range;
  } esc_result_t;

  // One row of the directed table: either a register write or a pixel beat.
  typedef struct {
    bit                     is_write;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    logic [INDEX_BITS-1:0]  col;
    logic [INDEX_BITS-1:0]  row;
    bit                     known;
    esc_result_t            want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mbet_pixel_if #(.INDEX_BITS(INDEX_BITS)) pix ();
  mbet_result_if                           res ();
  mbet_cfg_if                              cfg_ch ();

  mandelbrot_escape_time #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .INDEX_BITS(INDEX_BITS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pix),
    .result(res),
    .cfg   (cfg_ch)
  );

  cfg_t        shadow_cfg;
  esc_result_t expected_results[$];
  plan_row_t   directed_plan[$];
  int          error_count   = 0;
  int          hold_requests = 0;
  bit          calm          = 1'b0;

  // Free-running clock, 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("mandelbrot_escape_time_test: done, errors");
    $finish;
  end

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  // Maps the pixel to c and counts steps of z = z^2 + c until escape or the limit.
  function automatic esc_result_t predict_pixel(input cfg_t c, input logic [INDEX_BITS-1:0] col,
                                                input logic [INDEX_BITS-1:0] row);
    esc_result_t r;
    longint      cx, cy, x, y, ax, ay, xx, yy, xy, sxy;
    int unsigned count;
    r = '0;
    if ({1'b0, col} >= c.image_width || {1'b0, row} >= c.image_height) begin
      r.out_of_range = 1'b1;
      return r;
    end
    cx = clamp_coord(longint'($signed(c.start_x)) + longint'(col) * longint'(c.step_x));
    cy = clamp_coord(longint'($signed(c.start_y)) - longint'(row) * longint'(c.step_y));
    x = cx;
    y = cy;
    count = 0;
    while (count < c.max_iter) begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (ax > ESC_TWO || ay > ESC_TWO) break;
      xx = (ax * ax) >>> FRAC_BITS;
      yy = (ay * ay) >>> FRAC_BITS;
      if (xx + yy > ESC_FOUR) break;
      xy = (ax * ay) >>> (FRAC_BITS - 1);
      sxy = ((x < 0) != (y < 0)) ? -xy : xy;
      x = clamp_coord(xx - yy + cx);
      y = clamp_coord(sxy + cy);
      count++;
    end
    r.iterations = ITER_W'(count);
    r.inside_res = (count == c.max_iter);
    r.glyph      = r.inside_res ? GLYPH_INSIDE : GLYPH_W'(1 + count % 3);
    return r;
  endfunction

  function automatic esc_result_t mk_result(input int unsigned iters, input logic in_set,
                                            input logic [GLYPH_W-1:0] glyph, input logic oor);
    esc_result_t r;
    r.iterations   = ITER_W'(iters);
    r.inside_res   = in_set;
    r.glyph        = glyph;
    r.out_of_range = oor;
    return r;
  endfunction

  function automatic void plan_write(input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] value);
    plan_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.index    = idx;
    r.data     = value;
    directed_plan.push_back(r);
  endfunction

  function automatic void plan_pixel(input logic [INDEX_BITS-1:0] col,
                                     input logic [INDEX_BITS-1:0] row,
                                     input bit known = 1'b0, input esc_result_t want = '0);
    plan_row_t r;
    r = '{default: '0};
    r.col   = col;
    r.row   = row;
    r.known = known;
    r.want  = want;
    directed_plan.push_back(r);
  endfunction

  // One register write beat; the shadow copy follows once the beat is taken.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_MAX_ITER:     shadow_cfg.max_iter     = value[MAX_ITER_W-1:0];
      CFG_START_X:      shadow_cfg.start_x      = value[START_W-1:0];
      CFG_START_Y:      shadow_cfg.start_y      = value[START_W-1:0];
      CFG_STEP_X:       shadow_cfg.step_x       = value[STEP_W-1:0];
      CFG_STEP_Y:       shadow_cfg.step_y       = value[STEP_W-1:0];
      CFG_IMAGE_WIDTH:  shadow_cfg.image_width  = value[SIZE_W-1:0];
      CFG_IMAGE_HEIGHT: shadow_cfg.image_height = value[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  // One pixel beat after a random gap; valid stays high when the next gap is zero.
  task automatic send_pixel(input logic [INDEX_BITS-1:0] col, input logic [INDEX_BITS-1:0] row,
                            input bit known, input esc_result_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid     <= 1'b1;
    pix.pixel_col <= col;
    pix.pixel_row <= row;
    do @(posedge clk); while (!pix.ready);
    expected_results.push_back(known ? want : predict_pixel(shadow_cfg, col, row));
  endtask

  // Stops offering pixels and waits until every pending result has been taken.
  task automatic drain_results();
    pix.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Result side: random ready gaps, one long hold on request, compare with the oldest prediction.
  initial begin : result_sink
    int          gap;
    int          holds_done;
    esc_result_t want;
    holds_done = 0;
    res.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (holds_done < hold_requests) begin
        holds_done++;
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing pending, expected none, actual %0d/%0d/%0d/%0d",
                 $time, res.iterations, res.inside_res, res.glyph, res.out_of_range);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("iterations", want.iterations, res.iterations);
        check_field("inside_res", want.inside_res, res.inside_res);
        check_field("glyph", want.glyph, res.glyph);
        check_field("out_of_range", want.out_of_range, res.out_of_range);
      end
    end
  end

  // Stimulus: reset, directed table, then random phases with fresh register settings.
  initial begin : stimulus
    plan_row_t             step;
    bit                    writing;
    bit                    wild;
    int unsigned           width, height, span;
    logic [MAX_ITER_W-1:0] limit;
    logic [CFG_DATA_W-1:0] sx, sy, stx, sty, noise;
    logic [INDEX_BITS-1:0] col, row;

    shadow_cfg    = CFG_RESET;
    pix.valid     = 1'b0;
    pix.pixel_col = '0;
    pix.pixel_row = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;

    // Reset values: two opposite corners and the centre of the image, and just past each edge.
    plan_pixel(0, 0);
    plan_pixel(199, 99);
    plan_pixel(100, 50);
    plan_pixel(200, 0, 1'b1, mk_result(0, 1'b0, GLYPH_INSIDE, 1'b1));
    plan_pixel(0, 100, 1'b1, mk_result(0, 1'b0, GLYPH_INSIDE, 1'b1));
    plan_pixel(4095, 4095, 1'b1, mk_result(0, 1'b0, GLYPH_INSIDE, 1'b1));
    // A zero limit takes no step and counts as inside.
    plan_write(CFG_MAX_ITER, 32'd0);
    plan_pixel(0, 0, 1'b1, mk_result(0, 1'b1, GLYPH_INSIDE, 1'b0));
    plan_pixel(4095, 0, 1'b1, mk_result(0, 1'b0, GLYPH_INSIDE, 1'b1));
    // A zero-width image puts every pixel out of range.
    plan_write(CFG_MAX_ITER, 32'd1);
    plan_write(CFG_IMAGE_WIDTH, 32'd0);
    plan_pixel(0, 0, 1'b1, mk_result(0, 1'b0, GLYPH_INSIDE, 1'b1));
    // Extreme corner and steps: c saturates and escapes before the first step.
    plan_write(CFG_IMAGE_WIDTH, 32'd4096);
    plan_write(CFG_IMAGE_HEIGHT, 32'd4096);
    plan_write(CFG_START_X, Q_MOST_POS);
    plan_write(CFG_STEP_X, Q_MOST_POS);
    plan_write(CFG_START_Y, Q_MOST_NEG);
    plan_write(CFG_STEP_Y, Q_MOST_POS);
    plan_pixel(0, 0, 1'b1, mk_result(0, 1'b0, 2'd1, 1'b0));
    plan_pixel(4095, 4095, 1'b1, mk_result(0, 1'b0, 2'd1, 1'b0));
    plan_pixel(1, 4095);
    // Origin with the largest limit: runs every step and stays inside.
    plan_write(CFG_START_X, 32'd0);
    plan_write(CFG_STEP_X, 32'd0);
    plan_write(CFG_START_Y, 32'd0);
    plan_write(CFG_STEP_Y, 32'd0);
    plan_write(CFG_MAX_ITER, 32'hFFFF);
    plan_pixel(0, 0, 1'b1, mk_result(16'hFFFF, 1'b1, GLYPH_INSIDE, 1'b0));
    // Real axis at -2 (bounded), +2 (one step) and +6 (escapes at once).
    plan_write(CFG_MAX_ITER, 32'd50);
    plan_write(CFG_START_X, Q_MINUS_TWO);
    plan_write(CFG_STEP_X, Q_FOUR);
    plan_pixel(0, 0, 1'b1, mk_result(50, 1'b1, GLYPH_INSIDE, 1'b0));
    plan_pixel(1, 7, 1'b1, mk_result(1, 1'b0, 2'd2, 1'b0));
    plan_pixel(2, 0, 1'b1, mk_result(0, 1'b0, 2'd1, 1'b0));
    // The unused index must leave every register alone.
    plan_write(CFG_UNUSED, 32'hFFFF_FFFF);
    plan_pixel(0, 0, 1'b1, mk_result(50, 1'b1, GLYPH_INSIDE, 1'b0));
    // Widest image field, one row tall.
    plan_write(CFG_IMAGE_WIDTH, 32'h1FFF);
    plan_write(CFG_IMAGE_HEIGHT, 32'd1);
    plan_pixel(4095, 0, 1'b1, mk_result(0, 1'b0, 2'd1, 1'b0));
    plan_pixel(0, 1, 1'b1, mk_result(0, 1'b0, GLYPH_INSIDE, 1'b1));
    // Back to the default view.
    plan_write(CFG_MAX_ITER, 32'(CFG_RESET.max_iter));
    plan_write(CFG_START_X, 32'(CFG_RESET.start_x));
    plan_write(CFG_START_Y, 32'(CFG_RESET.start_y));
    plan_write(CFG_STEP_X, 32'(CFG_RESET.step_x));
    plan_write(CFG_STEP_Y, 32'(CFG_RESET.step_y));
    plan_write(CFG_IMAGE_WIDTH, 32'(CFG_RESET.image_width));
    plan_write(CFG_IMAGE_HEIGHT, 32'(CFG_RESET.image_height));
    plan_pixel(37, 12);
    plan_pixel(150, 80);
    plan_pixel(60, 45);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the table; registers change only after the block has gone quiet.
    writing = 1'b0;
    foreach (directed_plan[i]) begin
      step = directed_plan[i];
      if (step.is_write) begin
        if (!writing) drain_results();
        writing = 1'b1;
        write_reg(step.index, step.data);
      end else begin
        if (writing) cfg_ch.valid <= 1'b0;
        writing = 1'b0;
        send_pixel(step.col, step.row, step.known, step.want);
      end
    end

    // Random phases: mostly views framed on the set, two phases of raw register values.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      wild = (p == 4 || p == 8);
      calm = (p == 1 || p == 6 || p == 9);
      case (p)
        0:       limit = 16'd200;
        1:       limit = 16'd8;
        2:       limit = 16'd1;
        3:       limit = MAX_ITER_W'($urandom_range(20, 300));
        5:       limit = 16'd2;
        6:       limit = 16'd3;
        7:       limit = MAX_ITER_W'($urandom_range(100, 300));
        default: limit = MAX_ITER_W'($urandom_range(4, 60));
      endcase
      if (wild) begin
        width  = $urandom_range(0, 8191);
        height = $urandom_range(0, 8191);
        sx     = $urandom;
        sy     = $urandom;
        stx    = $urandom;
        sty    = $urandom;
      end else begin
        width  = ($urandom_range(0, 7) == 0) ? 4096 : $urandom_range(1, 64);
        height = ($urandom_range(0, 7) == 0) ? 4096 : $urandom_range(1, 64);
        span   = $urandom_range(1 << 28, 3 << 28);
        stx    = span / width;
        sx     = Q_MINUS_TWO + $urandom_range(0, 1 << 28);
        sy     = $urandom_range(1 << 27, 5 << 27);
        sty    = (2 * sy) / height;
      end

      // Bits above each register's width carry random noise.
      noise = $urandom;
      write_reg(CFG_MAX_ITER, {noise[31:16], limit});
      write_reg(CFG_START_X, sx);
      write_reg(CFG_START_Y, sy);
      noise = $urandom;
      write_reg(CFG_STEP_X, {noise[31], stx[30:0]});
      noise = $urandom;
      write_reg(CFG_STEP_Y, {noise[31], sty[30:0]});
      noise = $urandom;
      write_reg(CFG_IMAGE_WIDTH, {noise[31:13], width[12:0]});
      noise = $urandom;
      write_reg(CFG_IMAGE_HEIGHT, {noise[31:13], height[12:0]});
      cfg_ch.valid <= 1'b0;

      // Short limits and no idling here, so the long receiver hold backs up the input.
      if (p == 1) hold_requests++;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (!wild && $urandom_range(0, 99) < 85) begin
          col = INDEX_BITS'($urandom_range(0, width - 1));
          row = INDEX_BITS'($urandom_range(0, height - 1));
        end else begin
          col = INDEX_BITS'($urandom);
          row = INDEX_BITS'($urandom);
        end
        send_pixel(col, row, 1'b0, '0);
      end
    end

    drain_results();
    if (error_count == 0)
      $display("mandelbrot_escape_time_test: done, clean");
    else
      $display("mandelbrot_escape_time_test: done, errors");
    $finish;
  end

endmodule
